/* sv/dsk_pkg.sv */
// dsk_pkg: shared types and constants for the detection suppression block
// no dependencies

package dsk_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned CLASS_W = 8;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned THR_W   = 24;
  localparam int unsigned KEEP_W  = 4;
  localparam int unsigned DSQ_W   = 2 * COORD_W + 1;
  localparam int unsigned PADDR_W = 4;

  localparam logic [KEEP_W-1:0] KEEP_LIMIT = 4'd8;

  localparam logic [1:0] REG_DIST_SQ_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_FILTERED_CLASS    = 2'd1;
  localparam logic [1:0] REG_MAX_KEEP          = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
  } det_t;

  localparam int unsigned DET_W = $bits(det_t);

  typedef enum logic [1:0] {
    MODE_FILTER,
    MODE_SELECT,
    MODE_SUPPRESS
  } scan_mode_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FILT_START,
    ST_FILT_WAIT,
    ST_SEL_START,
    ST_SEL_WAIT,
    ST_SUP_START,
    ST_SUP_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       start;
    scan_mode_e mode;
    logic       set_top;
    logic       take;
    logic       emit;
    logic       last;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic any_alive;
    logic out_free;
  } sts_t;

endpackage

/* sv/dsk_ram.sv */
// dsk_ram: generic single write port ram with registered read
// no dependencies

module dsk_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dsk_ctrl.sv */
// dsk_ctrl: frame sequencer for load, filter, select, suppress and emit
// depends on dsk_pkg

module dsk_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  frame_end_i,
  output logic                  in_ready_o,
  input  logic [dsk_pkg::KEEP_W-1:0] max_keep_i,
  input  dsk_pkg::sts_t         sts_i,
  output dsk_pkg::cmd_t         cmd_o
);
  import dsk_pkg::*;

  state_e              state_q, state_d;
  logic [KEEP_W-1:0]   kept_q, kept_d;
  logic [KEEP_W-1:0]   limit;
  logic                last;

  always_comb begin
    if (max_keep_i == '0) begin
      limit = KEEP_W'(1);
    end else if (max_keep_i > KEEP_LIMIT) begin
      limit = KEEP_LIMIT;
    end else begin
      limit = max_keep_i;
    end
  end

  assign last = ((kept_q + KEEP_W'(1)) >= limit) || !sts_i.any_alive;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      kept_q  <= '0;
    end else begin
      state_q <= state_d;
      kept_q  <= kept_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kept_d     = kept_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mode = MODE_FILTER;
    cmd_o.last = last;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        kept_d     = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (frame_end_i) begin
            state_d = ST_FILT_START;
          end
        end
      end
      ST_FILT_START: begin
        cmd_o.start = 1'b1;
        cmd_o.mode  = MODE_FILTER;
        state_d     = ST_FILT_WAIT;
      end
      ST_FILT_WAIT: begin
        if (sts_i.done) begin
          cmd_o.set_top = 1'b1;
          state_d       = ST_SEL_START;
        end
      end
      ST_SEL_START: begin
        cmd_o.start = 1'b1;
        cmd_o.mode  = MODE_SELECT;
        state_d     = ST_SEL_WAIT;
      end
      ST_SEL_WAIT: begin
        if (sts_i.done) begin
          state_d = ST_SUP_START;
        end
      end
      ST_SUP_START: begin
        cmd_o.take  = 1'b1;
        cmd_o.start = 1'b1;
        cmd_o.mode  = MODE_SUPPRESS;
        state_d     = ST_SUP_WAIT;
      end
      ST_SUP_WAIT: begin
        if (sts_i.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          kept_d     = kept_q + KEEP_W'(1);
          if (last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            state_d = ST_SEL_START;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

/* sv/dsk_dp.sv */
// dsk_dp: detection store, scan pipeline, alive mask and output register
// depends on dsk_pkg and dsk_ram

module dsk_dp #(
  parameter int unsigned MAX_DETS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dsk_pkg::cmd_t                 cmd_i,
  output dsk_pkg::sts_t                 sts_o,
  input  dsk_pkg::det_t                 in_det_i,
  input  logic [dsk_pkg::THR_W-1:0]     dist_sq_threshold_i,
  input  logic [dsk_pkg::CLASS_W-1:0]   filtered_class_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output dsk_pkg::det_t                 out_det_o,
  output logic                          out_last_o,
  output logic                          overflow_o
);
  import dsk_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DETS);
  localparam int unsigned CW = $clog2(MAX_DETS + 1);

  logic [CW-1:0]       cnt_q;
  logic                ovf_q;
  logic [CW-1:0]       scan_cnt_q;
  logic                act_q;
  scan_mode_e          mode_q;
  logic                p1_vld_q;
  logic [AW-1:0]       p1_idx_q;
  det_t                rdata;
  logic                p2_vld_q;
  logic [AW-1:0]       p2_idx_q;
  det_t                p2_det_q;
  logic [DSQ_W-1:0]    p2_dsq_q;
  logic [MAX_DETS-1:0] alive_q;
  logic [COORD_W-1:0]  top_y_q;
  logic [AW-1:0]       top_idx_q;
  logic                found_q;
  det_t                best_q;
  logic [AW-1:0]       best_idx_q;
  logic                out_valid_q;
  det_t                out_det_q;
  logic                out_last_q;
  logic                out_ovf_q;
  logic [COORD_W-1:0]  dx, dy;
  logic [DSQ_W-1:0]    dsq;
  logic                we;

  assign we = cmd_i.load && (cnt_q < CW'(MAX_DETS));

  dsk_ram #(
    .WIDTH (DET_W),
    .DEPTH (MAX_DETS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_det_i),
    .raddr_i (scan_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    dx  = (rdata.x > best_q.x) ? rdata.x - best_q.x : best_q.x - rdata.x;
    dy  = (rdata.y > best_q.y) ? rdata.y - best_q.y : best_q.y - rdata.y;
    dsq = DSQ_W'(dx) * DSQ_W'(dx) + DSQ_W'(dy) * DSQ_W'(dy);
  end

  // frame fill count and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (we) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // scan address counter and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= 1'b0;
      scan_cnt_q <= '0;
      mode_q     <= MODE_FILTER;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
    end else begin
      p1_vld_q <= act_q;
      p2_vld_q <= p1_vld_q;
      if (cmd_i.start) begin
        act_q      <= 1'b1;
        scan_cnt_q <= '0;
        mode_q     <= cmd_i.mode;
      end else if (act_q) begin
        if (scan_cnt_q == cnt_q - CW'(1)) begin
          act_q <= 1'b0;
        end
        scan_cnt_q <= scan_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q <= scan_cnt_q[AW-1:0];
    p2_idx_q <= p1_idx_q;
    p2_det_q <= rdata;
    p2_dsq_q <= dsq;
  end

  // alive mask, smallest y search and best score search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        alive_q <= '0;
      end
      if (cmd_i.set_top) begin
        alive_q[top_idx_q] <= 1'b1;
      end
      if (cmd_i.take) begin
        alive_q[best_idx_q] <= 1'b0;
      end
      if (p2_vld_q) begin
        case (mode_q)
          MODE_FILTER: begin
            alive_q[p2_idx_q] <= (p2_det_q.cls != filtered_class_i);
          end
          MODE_SELECT: begin
            if (alive_q[p2_idx_q] && (!found_q || (p2_det_q.score > best_q.score))) begin
              found_q <= 1'b1;
            end
          end
          MODE_SUPPRESS: begin
            if (alive_q[p2_idx_q] && (p2_dsq_q < DSQ_W'(dist_sq_threshold_i))) begin
              alive_q[p2_idx_q] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_vld_q && (mode_q == MODE_FILTER) &&
        ((p2_idx_q == '0) || (p2_det_q.y < top_y_q))) begin
      top_y_q   <= p2_det_q.y;
      top_idx_q <= p2_idx_q;
    end
    if (p2_vld_q && (mode_q == MODE_SELECT) && alive_q[p2_idx_q] &&
        (!found_q || (p2_det_q.score > best_q.score))) begin
      best_q     <= p2_det_q;
      best_idx_q <= p2_idx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_det_q  <= best_q;
      out_last_q <= cmd_i.last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign sts_o.done      = !cmd_i.start && !act_q && !p1_vld_q && !p2_vld_q;
  assign sts_o.any_alive = |alive_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_det_o   = out_det_q;
  assign out_last_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

endmodule

/* sv/detection_suppress_top_k.sv */
// detection_suppress_top_k: per-frame greedy center-distance suppression, top k
// depends on dsk_pkg, dsk_ctrl, dsk_dp, dsk_ram
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid_i/ready_o  | pos_x, pos_y, class_id, score, frame_end
//  out     | out_valid_o/ready_i | out_x, out_y, out_class, out_score, out_last,
//          |                     | overflow
//  cfg     | apb psel/penable    | dist_sq_threshold, filtered_class, max_keep
//
// items load one per cycle; the item with frame_end closes the frame
// processing scans the store once to filter, then twice per kept item to select and
// suppress, all through the single ram read port
// no item is taken while a frame is processed; a stalled output holds the next emit
// reset clears counts, flags and state; the store needs no clearing

module detection_suppress_top_k #(
  parameter int unsigned MAX_DETS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dsk_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [dsk_pkg::COORD_W-1:0]   pos_y_i,
  input  logic [dsk_pkg::CLASS_W-1:0]   class_id_i,
  input  logic [dsk_pkg::SCORE_W-1:0]   score_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dsk_pkg::COORD_W-1:0]   out_x_o,
  output logic [dsk_pkg::COORD_W-1:0]   out_y_o,
  output logic [dsk_pkg::CLASS_W-1:0]   out_class_o,
  output logic [dsk_pkg::SCORE_W-1:0]   out_score_o,
  output logic                          out_last_o,
  output logic                          overflow_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dsk_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dsk_pkg::*;

  logic [THR_W-1:0]   thr_q;
  logic [CLASS_W-1:0] fcls_q;
  logic [KEEP_W-1:0]  keep_q;
  logic               wr_en;
  cmd_t               cmd;
  sts_t               sts;
  det_t               in_det;
  det_t               out_det;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_W'(200);
      fcls_q <= CLASS_W'(6);
      keep_q <= KEEP_W'(3);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DIST_SQ_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
        REG_FILTERED_CLASS:    fcls_q <= pwdata[CLASS_W-1:0];
        REG_MAX_KEEP:          keep_q <= pwdata[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIST_SQ_THRESHOLD: prdata = 32'(thr_q);
      REG_FILTERED_CLASS:    prdata = 32'(fcls_q);
      REG_MAX_KEEP:          prdata = 32'(keep_q);
      default:               prdata = '0;
    endcase
  end

  assign in_det = '{x: pos_x_i, y: pos_y_i, cls: class_id_i, score: score_i};

  dsk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_ready_o  (in_ready_o),
    .max_keep_i  (keep_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsk_dp #(
    .MAX_DETS (MAX_DETS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_det_i            (in_det),
    .dist_sq_threshold_i (thr_q),
    .filtered_class_i    (fcls_q),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .out_det_o           (out_det),
    .out_last_o          (out_last_o),
    .overflow_o          (overflow_o)
  );

  assign out_x_o     = out_det.x;
  assign out_y_o     = out_det.y;
  assign out_class_o = out_det.cls;
  assign out_score_o = out_det.score;

endmodule

/* dv/dsk_checker.sv */
`timescale 1ns / 100ps
// dsk_checker: predicts kept detections per frame and compares them with the output channel
// depends on dsk_pkg; instantiated beside the block by tb_detection_suppress_top_k

module dsk_checker #(
  parameter int unsigned MAX_DETS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [dsk_pkg::COORD_W-1:0] pos_x_i,
  input  logic [dsk_pkg::COORD_W-1:0] pos_y_i,
  input  logic [dsk_pkg::CLASS_W-1:0] class_id_i,
  input  logic [dsk_pkg::SCORE_W-1:0] score_i,
  input  logic                        frame_end_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [dsk_pkg::COORD_W-1:0] out_x_i,
  input  logic [dsk_pkg::COORD_W-1:0] out_y_i,
  input  logic [dsk_pkg::CLASS_W-1:0] out_class_i,
  input  logic [dsk_pkg::SCORE_W-1:0] out_score_i,
  input  logic                        out_last_i,
  input  logic                        overflow_i,
  input  logic                        cfg_wr_i,
  input  logic [dsk_pkg::PADDR_W-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import dsk_pkg::*;

  typedef struct packed {
    det_t det;
    logic last;
    logic ovf;
  } kept_t;

  logic [THR_W-1:0]   thr_q;
  logic [CLASS_W-1:0] fclass_q;
  logic [KEEP_W-1:0]  keep_q;
  det_t               frame_q[MAX_DETS];
  int                 count_q;
  logic               ovf_q;
  kept_t              kept_fifo[$];

  function automatic logic [DSQ_W-1:0] center_dist_sq(det_t a, det_t b);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    dx = (a.x > b.x) ? a.x - b.x : b.x - a.x;
    dy = (a.y > b.y) ? a.y - b.y : b.y - a.y;
    return DSQ_W'(dx) * DSQ_W'(dx) + DSQ_W'(dy) * DSQ_W'(dy);
  endfunction

  task automatic suppress_frame();
    int   top;
    int   order[$];
    logic alive[MAX_DETS];
    int   limit;
    int   kept;
    int   j;
    kept_t r;
    top = 0;
    for (int i = 1; i < count_q; i++)
      if (frame_q[i].y < frame_q[top].y) top = i;
    for (int i = 0; i < count_q; i++) begin
      alive[i] = (i == top) || (frame_q[i].cls != fclass_q);
      if (alive[i]) begin
        j = order.size();
        while (j > 0 && frame_q[order[j-1]].score < frame_q[i].score) j--;
        order.insert(j, i);
      end
    end
    limit = (keep_q == 0) ? 1 : ((keep_q > KEEP_LIMIT) ? int'(KEEP_LIMIT) : int'(keep_q));
    kept = 0;
    for (int i = 0; i < order.size() && kept < limit; i++) begin
      if (alive[order[i]]) begin
        for (int k = i + 1; k < order.size(); k++)
          if (alive[order[k]] &&
              center_dist_sq(frame_q[order[i]], frame_q[order[k]]) < DSQ_W'(thr_q))
            alive[order[k]] = 1'b0;
        r.det  = frame_q[order[i]];
        r.last = 1'b0;
        r.ovf  = ovf_q;
        kept_fifo = {kept_fifo, r};
        kept++;
      end
    end
    if (kept > 0) kept_fifo[kept_fifo.size()-1].last = 1'b1;
    count_q = 0;
    ovf_q   = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kept_t e;
    if (!rst_ni) begin
      thr_q        = 24'd200;
      fclass_q     = 8'd6;
      keep_q       = 4'd3;
      count_q      = 0;
      ovf_q        = 1'b0;
      fail_count_o = 0;
      kept_fifo.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (kept_fifo.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result x=%0d y=%0d", out_x_i, out_y_i);
        end else begin
          e = kept_fifo.pop_front();
          if (out_x_i !== e.det.x || out_y_i !== e.det.y || out_class_i !== e.det.cls ||
              out_score_i !== e.det.score || out_last_i !== e.last || overflow_i !== e.ovf) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch exp %0d %0d %0d %0d %b %b got %0d %0d %0d %0d %b %b",
                       e.det.x, e.det.y, e.det.cls, e.det.score, e.last, e.ovf,
                       out_x_i, out_y_i, out_class_i, out_score_i, out_last_i, overflow_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (count_q < MAX_DETS) begin
          frame_q[count_q] = '{x: pos_x_i, y: pos_y_i, cls: class_id_i, score: score_i};
          count_q++;
        end else ovf_q = 1'b1;
        if (frame_end_i && count_q > 0) suppress_frame();
      end
      if (cfg_wr_i) begin
        case (cfg_addr_i[3:2])
          REG_DIST_SQ_THRESHOLD: thr_q    = cfg_data_i[THR_W-1:0];
          REG_FILTERED_CLASS:    fclass_q = cfg_data_i[CLASS_W-1:0];
          REG_MAX_KEEP:          keep_q   = cfg_data_i[KEEP_W-1:0];
          default: ;
        endcase
      end
      pending_o = kept_fifo.size();
    end
  end

endmodule

/* dv/tb_detection_suppress_top_k.sv */
`timescale 1ns / 100ps
// tb_detection_suppress_top_k: stimulus, register phases and verdict for the suppression block
// depends on dsk_pkg, detection_suppress_top_k and dsk_checker

module tb_detection_suppress_top_k;
  import dsk_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COORD_W-1:0]  pos_x = '0;
  logic [COORD_W-1:0]  pos_y = '0;
  logic [CLASS_W-1:0]  class_id = '0;
  logic [SCORE_W-1:0]  score = '0;
  logic                frame_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [CLASS_W-1:0]  out_class;
  logic [SCORE_W-1:0]  out_score;
  logic                out_last;
  logic                overflow;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  bit                  hold_off = 1'b0;
  int                  idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  detection_suppress_top_k dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .class_id_i(class_id), .score_i(score),
    .frame_end_i(frame_end),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_x_o(out_x), .out_y_o(out_y), .out_class_o(out_class), .out_score_o(out_score),
    .out_last_o(out_last), .overflow_o(overflow),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dsk_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .class_id_i(class_id), .score_i(score),
    .frame_end_i(frame_end),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_x_i(out_x), .out_y_i(out_y), .out_class_i(out_class), .out_score_i(out_score),
    .out_last_i(out_last), .overflow_i(overflow),
    .cfg_wr_i(psel && penable && pwrite && pready), .cfg_addr_i(paddr), .cfg_data_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall per item, plus one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    forever begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (hold_off && !held) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_det(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [CLASS_W-1:0] c, logic [SCORE_W-1:0] s, logic last,
                          bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    pos_x     <= x;
    pos_y     <= y;
    class_id  <= c;
    score     <= s;
    frame_end <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // clustered random frame: nearby centers and a share of the filtered class
  task automatic random_frame(int n, logic [CLASS_W-1:0] fcls);
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    cx = $urandom;
    cy = $urandom;
    for (int i = 0; i < n; i++)
      send_det(($urandom_range(0, 1) != 0) ? COORD_W'(cx + $urandom_range(0, 40)) :
                 COORD_W'($urandom),
               ($urandom_range(0, 1) != 0) ? COORD_W'(cy + $urandom_range(0, 40)) :
                 COORD_W'($urandom),
               ($urandom_range(0, 2) == 0) ? fcls : CLASS_W'($urandom),
               ($urandom_range(0, 3) == 0) ? SCORE_W'($urandom_range(0, 3)) :
                 SCORE_W'($urandom),
               i == n - 1, 1'b0);
  endtask

  initial begin
    int sent;
    logic [CLASS_W-1:0] fcls;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, extremes, ties, filtered class, single item
    send_det(12'd0, 12'd0, 8'd6, 16'hffff, 1'b1, 1'b0);
    send_det(12'd100, 12'd50, 8'd6, 16'd10, 1'b0, 1'b0);
    send_det(12'd100, 12'd50, 8'd6, 16'd10, 1'b0, 1'b0);
    send_det(12'd105, 12'd60, 8'd1, 16'd10, 1'b0, 1'b0);
    send_det(12'd4095, 12'd4095, 8'd255, 16'd0, 1'b0, 1'b0);
    send_det(12'd110, 12'd55, 8'd6, 16'd500, 1'b0, 1'b0);
    send_det(12'd4000, 12'd0, 8'd2, 16'hffff, 1'b1, 1'b0);
    drain();
    reg_write(REG_DIST_SQ_THRESHOLD, 32'd0);
    reg_write(REG_FILTERED_CLASS, 32'd255);
    reg_write(REG_MAX_KEEP, 32'd0);
    send_det(12'd5, 12'd5, 8'd255, 16'd7, 1'b0, 1'b0);
    send_det(12'd5, 12'd5, 8'd0, 16'd7, 1'b1, 1'b0);
    drain();
    reg_write(REG_DIST_SQ_THRESHOLD, 32'hffffff);
    reg_write(REG_MAX_KEEP, 32'd15);
    for (int i = 0; i < 4; i++) send_det(12'($urandom), 12'($urandom), 8'd0, 16'($urandom),
                                         i == 3, 1'b0);
    drain();
    reg_write(REG_DIST_SQ_THRESHOLD, 32'd1);
    reg_write(REG_FILTERED_CLASS, 32'd0);
    reg_write(REG_MAX_KEEP, 32'd8);

    // overflow frame, then a frame offered while the receiver holds off
    hold_off = 1'b1;
    for (int i = 0; i < 66; i++)
      send_det(12'($urandom), 12'($urandom), 8'($urandom), 16'($urandom), i == 65, 1'b1);
    random_frame(6, 8'd0);
    drain();

    sent = 0;
    while (sent < 100) begin
      case ($urandom_range(0, 3))
        0: reg_write(REG_DIST_SQ_THRESHOLD, $urandom_range(0, 3000));
        1: reg_write(REG_FILTERED_CLASS, $urandom_range(0, 7));
        2: reg_write(REG_MAX_KEEP, $urandom_range(0, 15));
        default: reg_write(REG_DIST_SQ_THRESHOLD, $urandom & 32'hffffff);
      endcase
      fcls = $urandom_range(0, 7);
      reg_write(REG_FILTERED_CLASS, fcls);
      for (int f = 0; f < 4; f++) begin
        int n;
        n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
        random_frame(n, fcls);
        sent += n;
      end
      drain();
    end
    drain();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
